[rtl/hfla_pkg.sv]
// ----------------------------------------------------------------------------
// hfla_pkg: shared types and codes of the handle free list allocator
// request and result payloads, command and status codes, control structs
// ----------------------------------------------------------------------------
`default_nettype none

package hfla_pkg;

   localparam int CMD_W            = 2;
   localparam int HANDLE_W         = 8;
   localparam int VALUE_W          = 31;
   localparam int STATUS_W         = 2;
   localparam int DEF_NUM_HANDLES  = 64;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [HANDLE_W-1:0] handle_in;
      logic [VALUE_W-1:0]  bind_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle_out;
      logic [VALUE_W-1:0]  bound_value;
   } rsp_type;

   // free stack control
   typedef struct packed {
      logic                rd;
      logic                pop;
      logic                push;
      logic [HANDLE_W-1:0] push_handle;
   } stk_ctl_type;

   // bind table control
   typedef struct packed {
      logic                rd;
      logic [HANDLE_W-1:0] rd_addr;
      logic                wr;
      logic [HANDLE_W-1:0] wr_addr;
      logic [VALUE_W-1:0]  wr_data;
   } tbl_ctl_type;

endpackage

`default_nettype wire

[rtl/hfla_free_stack.sv]
// ----------------------------------------------------------------------------
// hfla_free_stack: lifo of free handle indices
// synchronous memory with registered read, fill count, and per-entry written
// bits so that an untouched entry reads as its reset index
// ----------------------------------------------------------------------------
`default_nettype none

module hfla_free_stack
   import hfla_pkg::*;
#(
   parameter int NUM_HANDLES = DEF_NUM_HANDLES,
   localparam int IDX_W = $clog2(NUM_HANDLES),
   localparam int CNT_W = $clog2(NUM_HANDLES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stk_ctl_type       ctl,
   output logic      [IDX_W-1:0]  top_idx,
   output logic      [CNT_W-1:0]  count
);

   logic [IDX_W-1:0]       mem [NUM_HANDLES];
   logic [NUM_HANDLES-1:0] written_ff, written_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       rd_data_ff;
   logic [IDX_W-1:0]       rd_addr_ff;
   logic                   rd_fresh_ff;
   logic [IDX_W-1:0]       top_addr;
   logic [IDX_W-1:0]       push_addr;
   logic                   push_ok;

   assign top_addr  = IDX_W'(count_ff - CNT_W'(1));
   assign push_addr = count_ff[IDX_W-1:0];
   assign push_ok   = ctl.push && (count_ff < CNT_W'(NUM_HANDLES));

   always_comb begin
      count_in   = count_ff;
      written_in = written_ff;
      if (ctl.pop && (count_ff != '0)) begin
         count_in = count_ff - CNT_W'(1);
      end else if (push_ok) begin
         count_in              = count_ff + CNT_W'(1);
         written_in[push_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= CNT_W'(NUM_HANDLES);
         written_ff <= '0;
      end else begin
         count_ff   <= count_in;
         written_ff <= written_in;
      end
   end

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push_ok && !ctl.pop) begin
         mem[push_addr] <= ctl.push_handle[IDX_W-1:0];
      end
      if (ctl.rd) begin
         rd_data_ff  <= mem[top_addr];
         rd_addr_ff  <= top_addr;
         rd_fresh_ff <= written_ff[top_addr];
      end
   end

   // untouched entries hold the reset order, zero on top
   assign top_idx = rd_fresh_ff ? rd_data_ff : (IDX_W'(NUM_HANDLES - 1) - rd_addr_ff);
   assign count   = count_ff;

endmodule

`default_nettype wire

[rtl/hfla_bind_table.sv]
// ----------------------------------------------------------------------------
// hfla_bind_table: descriptor storage, one entry per handle
// synchronous memory, one write and one registered read a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hfla_bind_table
   import hfla_pkg::*;
#(
   parameter int NUM_HANDLES = DEF_NUM_HANDLES,
   localparam int IDX_W = $clog2(NUM_HANDLES)
) (
   input  wire logic               clock,
   input  wire tbl_ctl_type        ctl,
   output logic      [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [NUM_HANDLES];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[ctl.wr_addr[IDX_W-1:0]] <= ctl.wr_data;
      end
      if (ctl.rd) begin
         rd_data_ff <= mem[ctl.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/handle_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// handle_free_list_allocator_top: handle allocator with lifo free list
// allocate pops a free handle and binds a descriptor, lookup returns the
// descriptor of an active handle, release returns it and frees the handle
// ----------------------------------------------------------------------------
// In the cycle a request is accepted the free stack and the bind table are
// read (both memories have a registered read), and in the execute state that
// follows the result is formed and the stack, table and active marks are
// written back. A new request is taken only once the execute state has
// completed, so the block is through with one request before it takes the next.
// The result sits in an output register; the block keeps taking requests
// while it waits, and stalls in its execute state only when the output
// register still holds an untaken result. After reset every handle is free
// and handle 0 is handed out first; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_free_list_allocator_top
   import hfla_pkg::*;
#(
   parameter int NUM_HANDLES = DEF_NUM_HANDLES
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(NUM_HANDLES);
   localparam int CNT_W = $clog2(NUM_HANDLES + 1);

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                   state_ff, state_in;
   req_type                req_ff;
   logic [NUM_HANDLES-1:0] active_ff, active_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   req_fire;
   logic                   exec_done;
   stk_ctl_type            stk_ctl;
   tbl_ctl_type            tbl_ctl;
   logic [IDX_W-1:0]       top_idx;
   logic [CNT_W-1:0]       free_count;
   logic [VALUE_W-1:0]     tbl_rd_data;
   logic [IDX_W-1:0]       h_idx;
   logic                   h_ok;
   logic                   have_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // execute state completes once the output register can take the result
   assign exec_done = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // handle check against the latched request
   assign h_idx     = req_ff.handle_in[IDX_W-1:0];
   assign h_ok      = ({1'b0, req_ff.handle_in} < (HANDLE_W + 1)'(NUM_HANDLES))
                      && active_ff[h_idx];
   assign have_free = (free_count != '0);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      stk_ctl             = '0;
      stk_ctl.rd          = req_fire;
      stk_ctl.push_handle = req_ff.handle_in;

      tbl_ctl         = '0;
      tbl_ctl.rd      = req_fire;
      tbl_ctl.rd_addr = req_data.handle_in;
      tbl_ctl.wr_addr = req_ff.handle_in;
      tbl_ctl.wr_data = req_ff.bind_value;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_INVALID, handle_out: '0, bound_value: '0};
               case (req_ff.cmd)
                  CMD_ALLOC: begin
                     if (have_free) begin
                        // pop, mark active, bind the descriptor
                        stk_ctl.pop        = 1'b1;
                        active_in[top_idx] = 1'b1;
                        tbl_ctl.wr         = 1'b1;
                        tbl_ctl.wr_addr    = HANDLE_W'(top_idx);
                        rsp_in.status      = ST_OK;
                        rsp_in.handle_out  = HANDLE_W'(top_idx);
                     end else begin
                        rsp_in.status = ST_NONE_FREE;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (h_ok) begin
                        rsp_in.status      = ST_OK;
                        rsp_in.bound_value = tbl_rd_data;
                     end
                  end
                  CMD_RELEASE: begin
                     if (h_ok) begin
                        // clear the entry and push the handle back
                        stk_ctl.push       = 1'b1;
                        active_in[h_idx]   = 1'b0;
                        tbl_ctl.wr         = 1'b1;
                        tbl_ctl.wr_data    = '0;
                        rsp_in.status      = ST_OK;
                        rsp_in.bound_value = tbl_rd_data;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_INVALID;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   hfla_free_stack #(
      .NUM_HANDLES (NUM_HANDLES)
   ) u_free_stack (
      .clock   (clock),
      .reset   (reset),
      .ctl     (stk_ctl),
      .top_idx (top_idx),
      .count   (free_count)
   );

   hfla_bind_table #(
      .NUM_HANDLES (NUM_HANDLES)
   ) u_bind_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .rd_data (tbl_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // free handles and active handles always add up to the table size
   a_conservation: assert property (@(posedge clock) disable iff (reset)
      (32'(free_count) + 32'($countones(active_ff))) == 32'(NUM_HANDLES))
      else $error("free count and active marks out of balance");

   // an allocation never hands out a handle that is already active
   a_alloc_fresh: assert property (@(posedge clock) disable iff (reset)
      (exec_done && (req_ff.cmd == CMD_ALLOC) && have_free) |-> !active_ff[top_idx])
      else $error("allocated handle already active");

   // an accepted request moves the sequencer into its execute state
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execution");

   // completion always loads a result into the output register
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_done |=> rsp_valid_ff)
      else $error("completed request left no result");

endmodule

`default_nettype wire

[tb/handle_free_list_allocator_top_tb.sv]
// ----------------------------------------------------------------------------
// handle_free_list_allocator_top_tb: self-checking bench of the handle allocator
// a scoreboard tracks the free stack, bind table and active marks; every
// request is predicted on acceptance and each result is checked in order,
// under directed corner cases, full exhaustion and random mixes with idling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module handle_free_list_allocator_top_tb;
   import hfla_pkg::*;

   localparam int HANDLES     = DEF_NUM_HANDLES;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 10;
   // the spare command code, which the block must reject
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // clock, reset and the block's ports; the inputs driven here are known from time zero
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // idling knobs, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // scoreboard copy of the allocator state
   logic [HANDLE_W-1:0] spare_stack [HANDLES];
   int                  spare_count;
   logic [VALUE_W-1:0]  desc_table  [HANDLES];
   logic                in_use      [HANDLES];

   // results still owed by the block, oldest first
   rsp_type owed_results[$];

   // run statistics
   int cycle_count   = 0;
   int error_count   = 0;
   int result_count  = 0;
   int alloc_count   = 0;
   int lookup_count  = 0;
   int release_count = 0;
   int badcmd_count  = 0;
   int none_free_cnt = 0;
   int invalid_cnt   = 0;

   handle_free_list_allocator_top #(
      .NUM_HANDLES(HANDLES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: ready drops at random according to the stall knob
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results owed", cycle_count,
                  owed_results.size());
         $display("handle_free_list_allocator_top_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // scoreboard model
   // ---------------------------------------------------------------------

   // power-on state: every handle free, handle 0 on top
   task automatic clear_allocator_state();
      for (int i = 0; i < HANDLES; i++) begin
         spare_stack[i] = HANDLE_W'(HANDLES - 1 - i);
         desc_table[i]  = '0;
         in_use[i]      = 1'b0;
      end
      spare_count = HANDLES;
   endtask

   // apply one request to the scoreboard state and return its result
   function automatic rsp_type predict_handle_op(input req_type r);
      rsp_type res;
      int      h;
      res = '0;
      h   = int'(r.handle_in);
      case (r.cmd)
         CMD_ALLOC: begin
            if (spare_count == 0) begin
               res.status = ST_NONE_FREE;
            end else begin
               spare_count--;
               h              = int'(spare_stack[spare_count]);
               in_use[h]      = 1'b1;
               desc_table[h]  = r.bind_value;
               res.status     = ST_OK;
               res.handle_out = HANDLE_W'(h);
            end
         end
         CMD_LOOKUP: begin
            if (h >= HANDLES || !in_use[h]) begin
               res.status = ST_INVALID;
            end else begin
               res.status      = ST_OK;
               res.bound_value = desc_table[h];
            end
         end
         CMD_RELEASE: begin
            if (h >= HANDLES || !in_use[h]) begin
               res.status = ST_INVALID;
            end else begin
               res.status      = ST_OK;
               res.bound_value = desc_table[h];
               desc_table[h]   = '0;
               in_use[h]       = 1'b0;
               // a full stack cannot occur here, guarded anyway
               if (spare_count < HANDLES) begin
                  spare_stack[spare_count] = HANDLE_W'(h);
                  spare_count++;
               end
            end
         end
         default: res.status = ST_INVALID;
      endcase
      return res;
   endfunction

   // random active handle, or -1 when none is active
   function automatic int pick_live_handle();
      int live[$];
      for (int i = 0; i < HANDLES; i++) begin
         if (in_use[i]) live.push_back(i);
      end
      if (live.size() == 0) return -1;
      return live[$urandom_range(live.size() - 1)];
   endfunction

   function automatic logic [VALUE_W-1:0] random_desc();
      logic [31:0] raw;
      raw = $urandom;
      return raw[VALUE_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // send one request; ready is sampled at the falling edge, where it is
   // stable up to the rising edge that takes the request
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [HANDLE_W-1:0] handle,
                               input logic [VALUE_W-1:0] desc);
      req_type r;
      bit      taken;
      r.cmd        = cmd;
      r.handle_in  = handle;
      r.bind_value = desc;
      // optional idle cycles ahead of the request
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      owed_results.push_back(predict_handle_op(r));
      case (cmd)
         CMD_ALLOC:   alloc_count++;
         CMD_LOOKUP:  lookup_count++;
         CMD_RELEASE: release_count++;
         default:     badcmd_count++;
      endcase
   endtask

   // sender goes quiet until every owed result has come back
   task automatic hold_until_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------

   // handshake completes at the next rising edge, both sides are stable here
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (owed_results.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display("unexpected result at %0t: status %0d handle %0d value %h",
                        $realtime, rsp_data.status, rsp_data.handle_out,
                        rsp_data.bound_value);
         end else begin
            want = owed_results.pop_front();
            if (want.status == ST_NONE_FREE) none_free_cnt++;
            if (want.status == ST_INVALID)   invalid_cnt++;
            if (rsp_data.status !== want.status ||
                rsp_data.handle_out !== want.handle_out ||
                rsp_data.bound_value !== want.bound_value) begin
               error_count++;
               if (error_count <= SHOW_LIMIT)
                  $display({"mismatch at %0t: status %0d/%0d handle %0d/%0d ",
                            "value %h/%h (expected/actual)"}, $realtime,
                           want.status, rsp_data.status, want.handle_out,
                           rsp_data.handle_out, want.bound_value,
                           rsp_data.bound_value);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // corner cases straight out of reset
   task automatic test_directed();
      send_request(CMD_ALLOC,   8'd7,   {VALUE_W{1'b1}});  // gets handle 0
      send_request(CMD_ALLOC,   8'd255, '0);               // gets handle 1
      send_request(CMD_LOOKUP,  8'd0,   31'h2AAA_5555);    // value field ignored
      send_request(CMD_LOOKUP,  8'd1,   {VALUE_W{1'b1}});
      send_request(CMD_LOOKUP,  8'd2,   '0);               // in range, never taken
      send_request(CMD_LOOKUP,  HANDLE_W'(HANDLES), '0);   // first out-of-range handle
      send_request(CMD_LOOKUP,  8'd255, '0);
      send_request(CMD_RELEASE, 8'd255, '0);
      send_request(CMD_RELEASE, HANDLE_W'(HANDLES - 1), '0); // in range, inactive
      send_request(CMD_RELEASE, 8'd0,   '0);               // returns all-ones value
      send_request(CMD_LOOKUP,  8'd0,   '0);               // cleared by release
      send_request(CMD_RELEASE, 8'd0,   '0);               // double release
      send_request(CMD_ALLOC,   8'd0,   31'h1234_5678);    // lifo: handle 0 again
      send_request(CMD_LOOKUP,  8'd0,   '0);
      send_request(CMD_UNUSED,  8'd1,   31'h7FFF_0000);    // spare command code
      send_request(CMD_UNUSED,  8'd255, {VALUE_W{1'b1}});
      send_request(CMD_LOOKUP,  8'd1,   '0);               // untouched by spare code
      send_request(CMD_RELEASE, 8'd1,   '0);
      send_request(CMD_RELEASE, 8'd0,   '0);
      send_request(CMD_ALLOC,   8'd0,   31'h0000_0001);    // handle 0, pushed last
      send_request(CMD_RELEASE, 8'd0,   '0);
   endtask

   // drain the whole free stack, hit the empty case, then free everything
   task automatic test_exhaust_and_refill();
      int h;
      for (int i = 0; i < HANDLES + 2; i++)
         send_request(CMD_ALLOC, HANDLE_W'($urandom_range(255)), random_desc());
      send_request(CMD_LOOKUP,  HANDLE_W'($urandom_range(255, HANDLES)), random_desc());
      send_request(CMD_RELEASE, HANDLE_W'($urandom_range(255, HANDLES)), random_desc());
      h = pick_live_handle();
      while (h >= 0) begin
         if ($urandom_range(3) == 0)
            send_request(CMD_LOOKUP, HANDLE_W'(h), random_desc());
         send_request(CMD_RELEASE, HANDLE_W'(h), random_desc());
         h = pick_live_handle();
      end
      // stack is full again, releases must all fail
      send_request(CMD_RELEASE, HANDLE_W'($urandom_range(HANDLES - 1)), '0);
   endtask

   // random mix, mostly legal traffic on live handles with some noise;
   // a high allocate share keeps the table near full and the stack empty
   task automatic test_random_mix(input int count, input int alloc_pct);
      int pick;
      int h;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         h    = pick_live_handle();
         if (h < 0) h = $urandom_range(255);
         if (pick < alloc_pct)
            send_request(CMD_ALLOC, HANDLE_W'($urandom_range(255)), random_desc());
         else if (pick < alloc_pct + (88 - alloc_pct) / 2)
            send_request(CMD_LOOKUP, HANDLE_W'(h), random_desc());
         else if (pick < 88)
            send_request(CMD_RELEASE, HANDLE_W'(h), random_desc());
         else if (pick < 95)
            // any handle at all, most of them out of range
            send_request($urandom_range(1) ? CMD_LOOKUP : CMD_RELEASE,
                         HANDLE_W'($urandom_range(255)), random_desc());
         else
            send_request(CMD_UNUSED, HANDLE_W'($urandom_range(255)), random_desc());
      end
   endtask

   // ---------------------------------------------------------------------
   // run
   // ---------------------------------------------------------------------

   initial begin
      clear_allocator_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_exhaust_and_refill();

      // back to back, no idling on either side
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_mix(500, 40);

      // sender gaps only, heavy on allocate so the stack runs dry
      send_idle_pct = 49;
      test_random_mix(500, 60);

      // sender pauses until everything owed is back
      hold_until_quiet();

      // receiver stalls only, table drains down again
      send_idle_pct  = 0;
      recv_stall_pct = 49;
      test_random_mix(500, 30);
      test_exhaust_and_refill();

      // light idling on both sides
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      test_random_mix(500, 45);

      hold_until_quiet();
      repeat (8) @(posedge clock);

      $display("covered %0d allocates, %0d lookups, %0d releases, %0d spare codes",
               alloc_count, lookup_count, release_count, badcmd_count);
      $display("%0d results checked, %0d empty-stack, %0d bad-handle, %0d errors",
               result_count, none_free_cnt, invalid_cnt, error_count);
      if (error_count == 0 && owed_results.size() == 0) begin
         $display("handle_free_list_allocator_top_tb: clean");
      end else begin
         $display("handle_free_list_allocator_top_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
